// File: rtl/linear_interp_resampler_core_macros.svh
// Assertion macros shared by the resampler RTL.
// Depends on nothing; the including module must have clk and arst_n in scope.
`ifndef LINEAR_INTERP_RESAMPLER_CORE_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define LIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LIR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lir_pkg.sv
// Shared constants for the linear interpolation resampler.
// No dependencies; imported by lir_step, lir_back, the top level and the testbench.
`timescale 1ns / 1ps

package lir_pkg;

	// configuration register widths
	localparam int NOM_W      = 20;
	localparam int TRIM_W     = 18;
	localparam int LIM_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIM    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST   = 2'd2;

	// register reset values
	localparam logic [NOM_W-1:0]  NOM_RESET   = 20'd65536;
	localparam logic [TRIM_W-1:0] TRIM_RESET  = 18'd0;
	localparam logic [LIM_W-1:0]  BURST_RESET = 4'd8;

	// step arithmetic
	localparam int PROD_W = NOM_W + TRIM_W + 1;  // signed nominal * trim
	localparam int MAG_W  = 37;                  // |nominal * trim| < 2^37
	localparam int QUO_W  = 18;                  // quotient < 2^18
	localparam int STEP_W = 21;                  // step < 2^21
	localparam int SUM_W  = STEP_W + 1;
	localparam int PPM_W  = 20;
	localparam logic [PPM_W-1:0] PPM_SCALE = 20'd1000000;

	// M / 10^6 estimated as (M * RECIP) >> RECIP_SH; the estimate is low by at most one
	localparam int RECIP_W  = 21;
	localparam int RECIP_SH = 40;
	localparam logic [RECIP_W-1:0] RECIP = 21'd1099511;  // floor(2^40 / 10^6)
	localparam int LO_W  = 19;                  // low slice of the magnitude
	localparam int HI_W  = MAG_W - LO_W;        // high slice of the magnitude
	localparam int PPL_W = LO_W + RECIP_W;
	localparam int PPH_W = HI_W + RECIP_W;
	localparam int EST_W = MAG_W + RECIP_W;     // EST_W - RECIP_SH == QUO_W

endpackage

// File: rtl/lir_fifo.sv
// Small register FIFO between the front and back halves.
// Depends on nothing.
`timescale 1ns / 1ps

module lir_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		if (p == AW'(DEPTH - 1))
			return '0;
		return p + AW'(1);
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: rtl/lir_step.sv
// Phase step unit: step = nominal + nominal * trim / 10^6, at least 1.
// Multiply once, divide by reciprocal multiply plus one correction. Uses lir_pkg.
`timescale 1ns / 1ps

module lir_step (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic [lir_pkg::NOM_W-1:0]           nominal,
	input  logic signed [lir_pkg::TRIM_W-1:0]   trim,
	output logic                                step_valid,
	output logic [lir_pkg::STEP_W-1:0]          step
);
	import lir_pkg::*;

	typedef enum logic [2:0] {S_MUL, S_ABS, S_REC, S_EST, S_CHK, S_COR, S_FIN, S_DONE} state_t;

	state_t                    state_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      neg_q;
	logic [MAG_W-1:0]          mag_q;
	logic [PPH_W-1:0]          pp_hi_q;
	logic [PPL_W-1:0]          pp_lo_q;
	logic [QUO_W-1:0]          quo_q;
	logic [MAG_W-1:0]          back_q;
	logic [STEP_W-1:0]         step_q;

	logic signed [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]         mag_full;
	logic [PPH_W-1:0]          pp_hi;
	logic [PPL_W-1:0]          pp_lo;
	logic [EST_W-1:0]          est_full;
	logic [MAG_W-1:0]          back;
	logic [MAG_W-1:0]          rem;
	logic signed [QUO_W:0]     delta;
	logic signed [SUM_W-1:0]   sum;

	assign prod     = $signed({1'b0, nominal}) * trim;
	assign mag_full = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	// split the magnitude so each partial product stays narrow
	assign pp_hi    = PPH_W'(mag_q[MAG_W-1:LO_W]) * PPH_W'(RECIP);
	assign pp_lo    = PPL_W'(mag_q[LO_W-1:0]) * PPL_W'(RECIP);
	assign est_full = {pp_hi_q, {LO_W{1'b0}}} + EST_W'(pp_lo_q);
	assign back     = MAG_W'(quo_q) * MAG_W'(PPM_SCALE);
	assign rem      = mag_q - back_q;
	assign delta    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign sum      = $signed({2'b00, nominal}) + SUM_W'(delta);

	assign step_valid = (state_q == S_DONE);
	assign step       = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_MUL;
			prod_q  <= '0;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			pp_hi_q <= '0;
			pp_lo_q <= '0;
			quo_q   <= '0;
			back_q  <= '0;
			step_q  <= '0;
		end else if (restart) begin
			state_q <= S_MUL;
		end else begin
			unique case (state_q)
				S_MUL: begin
					prod_q  <= prod;
					state_q <= S_ABS;
				end
				S_ABS: begin
					neg_q   <= prod_q[PROD_W-1];
					mag_q   <= mag_full[MAG_W-1:0];
					state_q <= S_REC;
				end
				S_REC: begin
					pp_hi_q <= pp_hi;
					pp_lo_q <= pp_lo;
					state_q <= S_EST;
				end
				S_EST: begin
					quo_q   <= est_full[EST_W-1:RECIP_SH];
					state_q <= S_CHK;
				end
				S_CHK: begin
					back_q  <= back;
					state_q <= S_COR;
				end
				S_COR: begin
					// estimate may be one short
					if (rem >= MAG_W'(PPM_SCALE))
						quo_q <= quo_q + QUO_W'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					// clamp: a zero or negative step becomes one
					if (sum < SUM_W'(1))
						step_q <= STEP_W'(1);
					else
						step_q <= sum[STEP_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: ;
				default: state_q <= S_MUL;
			endcase
		end
	end

endmodule

// File: rtl/lir_front.sv
// Front half: takes input samples, primes the sample pair, queues segments.
// Depends on nothing; feeds lir_fifo.
`timescale 1ns / 1ps

module lir_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [SAMPLE_BITS-1:0]     in_sample,
	output logic                       in_ready,
	input  logic                       step_valid,
	input  logic                       q_full,
	output logic                       q_push,
	output logic [2*SAMPLE_BITS-1:0]   q_data
);

	logic [SAMPLE_BITS-1:0] cur_q;
	logic                   primed_q;
	logic                   accept;

	assign in_ready = step_valid && !q_full;
	assign accept   = in_valid && in_ready;
	// first sample after reset only fills the pair
	assign q_push   = accept && primed_q;
	assign q_data   = {in_sample, cur_q};   // {cur, prev}

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			cur_q    <= in_sample;
			primed_q <= 1'b1;
		end
	end

endmodule

// File: rtl/lir_back.sv
// Back half: walks the phase across one segment and emits interpolated samples.
// Two-stage output pipe (multiply, then add). Uses lir_pkg; fed by lir_fifo.
`timescale 1ns / 1ps

module lir_back #(
	parameter int SAMPLE_BITS = 16,
	parameter int PHASE_BITS  = 16,
	parameter int MAX_BURST   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  logic [2*SAMPLE_BITS-1:0]      q_data,
	output logic                          q_pop,
	input  logic [lir_pkg::STEP_W-1:0]    step,
	input  logic [lir_pkg::LIM_W-1:0]     burst_limit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [SAMPLE_BITS-1:0]        out_sample,
	output logic                          out_last
);
	import lir_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int PW    = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;
	localparam int CNT_W = $clog2(MAX_BURST + 1);
	localparam int LW    = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam int PRD_W = SB + PHASE_BITS + 2;
	localparam logic [PW-1:0] PHASE_ONE = PW'(1) << PHASE_BITS;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                  state_q;
	logic [PW-1:0]           phase_q;
	logic [LW-1:0]           n_q;
	logic signed [SB-1:0]    prev_q;
	logic signed [SB:0]      diff_q;

	logic                    v_s1, v_s2;
	logic signed [PRD_W-1:0] prod_s1;
	logic signed [SB-1:0]    prev_s1;
	logic                    last_s1;
	logic [SB-1:0]           out_s2;
	logic                    last_s2;

	logic [LW-1:0]           lim_ext, eff_lim;
	logic                    emit_ok, issue, can_s1, can_s2, last;
	logic [PW-1:0]           phase_nxt;
	logic signed [PRD_W-1:0] prod;
	logic signed [PRD_W-1:0] prod_sh;
	logic signed [SB+1:0]    sum;
	logic signed [SB-1:0]    pop_prev, pop_cur;

	assign pop_prev = q_data[SB-1:0];
	assign pop_cur  = q_data[2*SB-1:SB];

	assign lim_ext = LW'(burst_limit);
	assign eff_lim = (lim_ext > LW'(MAX_BURST)) ? LW'(MAX_BURST) : lim_ext;

	assign can_s2  = !v_s2 || out_ready;
	assign can_s1  = !v_s1 || can_s2;
	assign emit_ok = (phase_q < PHASE_ONE) && (n_q < eff_lim);
	assign issue   = (state_q == ST_RUN) && emit_ok && can_s1;
	assign q_pop   = (state_q == ST_IDLE) && !q_empty;

	assign phase_nxt = phase_q + PW'(step);
	assign last      = (phase_nxt >= PHASE_ONE) || ((n_q + LW'(1)) == eff_lim);
	assign prod      = diff_q * $signed({1'b0, phase_q[PHASE_BITS-1:0]});

	// arithmetic shift floors, matching the fixed-point definition
	assign prod_sh = prod_s1 >>> PHASE_BITS;
	assign sum     = (SB+2)'(prev_s1) + prod_sh[SB+1:0];

	assign out_valid  = v_s2;
	assign out_sample = out_s2;
	assign out_last   = last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			n_q     <= '0;
			prev_q  <= '0;
			diff_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			prod_s1 <= '0;
			prev_s1 <= '0;
			last_s1 <= 1'b0;
			out_s2  <= '0;
			last_s2 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						prev_q  <= pop_prev;
						diff_q  <= (SB+1)'(pop_cur) - (SB+1)'(pop_prev);
						n_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (emit_ok) begin
						if (can_s1) begin
							phase_q <= phase_nxt;
							n_q     <= n_q + LW'(1);
						end
					end else begin
						// segment done: retire one unit if the phase reached it
						if (phase_q >= PHASE_ONE)
							phase_q <= phase_q - PHASE_ONE;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (can_s1) begin
				v_s1 <= issue;
				if (issue) begin
					prod_s1 <= prod;
					prev_s1 <= prev_q;
					last_s1 <= last;
				end
			end

			if (can_s2) begin
				v_s2 <= v_s1;
				if (v_s1) begin
					out_s2  <= sum[SB-1:0];
					last_s2 <= last_s1;
				end
			end
		end
	end

endmodule

// File: rtl/linear_interp_resampler_core.sv
// Top level of the linear interpolation resampler: config registers, step unit,
// front, segment queue and back. Uses lir_pkg and the shared assertion macros.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata: in_sample
//   m_*       out  m_tvalid/m_tready  m_tdata: out_sample, m_tlast: last_of_burst
//   cfg_*     in   cfg_we             cfg_index, cfg_data
//
// Front takes one input beat per cycle while the step is valid and the two-entry
// segment queue has room. Back loads a segment, issues its output beats (0 to 8)
// while the output pipe can take them, then retires it. Output beats pass the
// multiply stage and then the add stage after issue. After reset and after any
// config write the step unit runs through multiply, magnitude, reciprocal products,
// quotient estimate, back-multiply, correction and clamp; s_tready stays low meanwhile.
// m_tready low stalls the output pipe and then the back; the queue decouples the front.
`timescale 1ns / 1ps
`include "linear_interp_resampler_core_macros.svh"

module linear_interp_resampler_core #(
	parameter int SAMPLE_BITS = 16,
	parameter int PHASE_BITS  = 16,
	parameter int MAX_BURST   = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// stream in
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] in_sample
	// stream out
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // [SAMPLE_BITS-1:0] out_sample
	output logic                                 m_tlast,   // last_of_burst
	// config write port
	input  logic                                 cfg_we,
	input  logic [lir_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lir_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import lir_pkg::*;

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int QW      = 2 * SAMPLE_BITS;

	// control registers
	logic [NOM_W-1:0]          nominal_q;
	logic signed [TRIM_W-1:0]  trim_q;
	logic [LIM_W-1:0]          burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= NOM_RESET;
			trim_q    <= TRIM_RESET;
			burst_q   <= BURST_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NOMINAL: nominal_q <= cfg_data[NOM_W-1:0];
				CFG_TRIM:    trim_q    <= cfg_data[TRIM_W-1:0];
				CFG_BURST:   burst_q   <= cfg_data[LIM_W-1:0];
				default: ;   // unmapped index, write dropped
			endcase
		end
	end

	// step unit restarts on any write so it always tracks the live registers
	logic              step_valid;
	logic [STEP_W-1:0] step;

	lir_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_we),
		.nominal    (nominal_q),
		.trim       (trim_q),
		.step_valid (step_valid),
		.step       (step)
	);

	logic          fifo_push, fifo_pop, fifo_full, fifo_empty;
	logic [QW-1:0] fifo_wr, fifo_rd;

	lir_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_sample  (s_tdata[SAMPLE_BITS-1:0]),
		.in_ready   (s_tready),
		.step_valid (step_valid),
		.q_full     (fifo_full),
		.q_push     (fifo_push),
		.q_data     (fifo_wr)
	);

	lir_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fifo_push),
		.wr_data (fifo_wr),
		.full    (fifo_full),
		.pop     (fifo_pop),
		.rd_data (fifo_rd),
		.empty   (fifo_empty)
	);

	logic [SAMPLE_BITS-1:0] out_sample;

	lir_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PHASE_BITS  (PHASE_BITS),
		.MAX_BURST   (MAX_BURST)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (fifo_empty),
		.q_data      (fifo_rd),
		.q_pop       (fifo_pop),
		.step        (step),
		.burst_limit (burst_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_sample  (out_sample),
		.out_last    (m_tlast)
	);

	assign m_tdata = TDATA_W'(out_sample);

	// queue never overrun or underrun
	`LIR_ASSERT(a_no_push_full, fifo_push |-> !fifo_full, "segment queue pushed while full")
	`LIR_ASSERT(a_no_pop_empty, fifo_pop |-> !fifo_empty, "segment queue popped while empty")
	// no beat taken before the step settles
	`LIR_ASSERT(a_step_ready, (s_tvalid && s_tready) |-> step_valid, "input beat without step")
	// step only drops because of a register write
	`LIR_ASSERT(a_step_restart, $fell(step_valid) |-> $past(cfg_we), "step dropped unprompted")

endmodule

// File: tb/lir_stream_checker.sv
// Stream checker for the linear interpolation resampler: mirrors the config
// registers, predicts every output beat and compares it with what the block sends.
// Depends on lir_pkg for register widths, indexes and reset values.
`timescale 1ns / 1ps

module lir_stream_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [15:0]                    s_tdata,      // [15:0] in_sample
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [15:0]                    m_tdata,      // [15:0] out_sample
	input  logic                           m_tlast,      // last_of_burst
	input  logic                           cfg_we,
	input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             open_beats,
	output int                             beats_checked
);
	import lir_pkg::*;

	localparam int     SAMPLE_W   = 16;
	localparam int     PHASE_BITS = 16;
	localparam int     MAX_OUT    = 8;
	localparam longint PHASE_ONE  = 64'sd1 << PHASE_BITS;
	localparam longint PPM_DIV    = 64'sd1000000;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} out_beat_t;

	out_beat_t predicted_q[$];

	logic        [NOM_W-1:0]    nom_r   = NOM_RESET;
	logic signed [TRIM_W-1:0]   trim_r  = TRIM_RESET;
	logic        [LIM_W-1:0]    lim_r   = BURST_RESET;
	logic signed [SAMPLE_W-1:0] prev_s  = '0;
	logic signed [SAMPLE_W-1:0] cur_s   = '0;
	longint                     phase_acc = 0;
	logic                       primed  = 1'b0;

	initial begin
		fail_count    = 0;
		open_beats    = 0;
		beats_checked = 0;
	end

	// one input sample: shift the pair, then emit while the phase is inside the segment and under the burst limit
	task automatic take_sample(input logic [SAMPLE_W-1:0] raw);
		longint    step;
		longint    diff;
		longint    q;
		longint    next_phase;
		int        limit;
		int        n;
		out_beat_t beat;
		prev_s = cur_s;
		cur_s  = raw;
		if (!primed) begin
			primed = 1'b1;
			return;
		end
		step = longint'(nom_r) + longint'(nom_r) * longint'(trim_r) / PPM_DIV;
		if (step < 1)
			step = 1;
		limit = (lim_r > MAX_OUT) ? MAX_OUT : int'(lim_r);
		n = 0;
		while (phase_acc < PHASE_ONE && n < limit) begin
			diff        = longint'(cur_s) - longint'(prev_s);
			q           = (diff * phase_acc) >>> PHASE_BITS;
			next_phase  = phase_acc + step;
			beat.sample = SAMPLE_W'(longint'(prev_s) + q);
			beat.last   = !(next_phase < PHASE_ONE && n + 1 < limit);
			predicted_q.push_back(beat);
			phase_acc = next_phase;
			n++;
		end
		if (phase_acc >= PHASE_ONE)
			phase_acc -= PHASE_ONE;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			nom_r     = NOM_RESET;
			trim_r    = TRIM_RESET;
			lim_r     = BURST_RESET;
			prev_s    = '0;
			cur_s     = '0;
			phase_acc = 0;
			primed    = 1'b0;
			predicted_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NOMINAL: nom_r  = cfg_data[NOM_W-1:0];
					CFG_TRIM:    trim_r = cfg_data[TRIM_W-1:0];
					CFG_BURST:   lim_r  = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_sample(s_tdata[SAMPLE_W-1:0]);
			if (m_tvalid && m_tready) begin
				beats_checked++;
				if (predicted_q.size() == 0) begin
					$error("unexpected output beat: out_sample %0d, last_of_burst %0b",
						$signed(m_tdata[SAMPLE_W-1:0]), m_tlast);
					fail_count++;
				end else begin
					want = predicted_q.pop_front();
					if (m_tdata[SAMPLE_W-1:0] !== want.sample) begin
						$error("out_sample mismatch: expected %0d, got %0d",
							$signed(want.sample), $signed(m_tdata[SAMPLE_W-1:0]));
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_burst mismatch: expected %0b, got %0b",
							want.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
		open_beats = predicted_q.size();
	end

endmodule

// File: tb/tb.sv
// Top of the resampler testbench: clock, reset, sample stimulus, config writes,
// output back-pressure and the verdict. Depends on lir_pkg, the resampler core
// and lir_stream_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;
	import lir_pkg::*;

	localparam int SAMPLE_W      = 16;
	localparam int DATA_W        = ((SAMPLE_W + 7) / 8) * 8;
	localparam int SETTLE_CYCLES = 48;      // step unit rerun plus back and pipe margin
	localparam int CYCLE_LIMIT   = 300000;
	localparam int BLOCK_BEATS   = 13;
	localparam int BLOCKS        = 3;
	localparam int HOLD_CYCLES   = 300;

	// index past the register list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic [TRIM_W-1:0] TRIM_MIN = 18'h20000;   // -131072
	localparam logic [TRIM_W-1:0] TRIM_MAX = 18'h1FFFF;   // +131071

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata   = '0;   // [15:0] in_sample
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [DATA_W-1:0]     m_tdata;          // [15:0] out_sample
	logic                  m_tlast;          // last_of_burst
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_NOMINAL;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fail_count;
	int open_beats;
	int beats_checked;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_cycles    = 0;
	int cycle_count    = 0;
	int beats_sent     = 0;
	int settings_used  = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	linear_interp_resampler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lir_stream_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.open_beats    (open_beats),
		.beats_checked (beats_checked)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls per cycle, or a long hold-off while hold_cycles runs down
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles--;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// offer one sample; idle gaps first, then hold tvalid until the beat is taken.
	// tready is looked at on the falling edge, away from the block's own updates.
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'(smp);
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		beats_sent++;
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [NOM_W-1:0] nom, input logic [TRIM_W-1:0] trim,
			input logic [LIM_W-1:0] lim);
		write_reg(CFG_NOMINAL, CFG_DATA_W'(nom));
		write_reg(CFG_TRIM, CFG_DATA_W'(trim));
		write_reg(CFG_BURST, CFG_DATA_W'(lim));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// wait for every predicted beat, then let silent inputs (prime, burst zero,
	// phase past one) finish inside the block before touching a register
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (open_beats != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] v;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0:       v = 16'h8000;
					1:       v = 16'h7FFF;
					2:       v = 16'hFFFF;
					default: v = 16'h0000;
				endcase
			end
			1:       v = SAMPLE_W'($urandom_range(64)) - 16'd32;
			default: v = SAMPLE_W'($urandom_range(16'hFFFF));
		endcase
		return v;
	endfunction

	task automatic random_config();
		logic [NOM_W-1:0]  nom;
		logic [TRIM_W-1:0] trim;
		logic [LIM_W-1:0]  lim;
		// mostly steps between 1/16 and ~3 units so results keep flowing
		case ($urandom_range(9))
			0:       nom = $urandom_range(1) ? 20'd0 : 20'd1;
			1:       nom = NOM_W'($urandom_range(20'hFFFFF));
			default: nom = NOM_W'($urandom_range(180000, 4096));
		endcase
		case ($urandom_range(5))
			0: begin
				case ($urandom_range(3))
					0:       trim = TRIM_MIN;
					1:       trim = TRIM_MAX;
					2:       trim = TRIM_W'(-100000);
					default: trim = TRIM_W'(100000);
				endcase
			end
			1:       trim = '0;
			default: trim = TRIM_W'($urandom_range(18'h3FFFF));
		endcase
		if ($urandom_range(3) == 0)
			lim = LIM_W'($urandom_range(15));   // includes zero and above the cap
		else
			lim = LIM_W'($urandom_range(8, 1));
		set_config(nom, trim, lim);
	endtask

	initial begin
		int extra;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, step of one unit: first beat primes, the rest copy prev
		send_sample(16'h0000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0001);
		settle();

		// quarter-unit step: four beats per input across full-scale swings,
		// negative slopes exercise the floor rounding of the shift
		set_config(20'd16384, '0, 4'd8);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		settle();

		// burst limit zero: nothing comes out
		set_config(20'd16384, '0, 4'd0);
		send_sample(16'h1234);
		send_sample(16'h4321);
		settle();

		// nominal zero forces step one; limit 15 is capped at eight
		set_config(20'd0, TRIM_MIN, 4'd15);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		settle();

		// step above two units: some inputs emit nothing and only retire a unit
		set_config(20'd196608, TRIM_MIN, 4'd8);
		send_sample(16'h4000);
		send_sample(16'hC000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		settle();

		// write to an index past the list, then the largest step with maximum trim
		write_reg(CFG_SPARE, 20'hFFFFF);
		set_config(20'hFFFFF, TRIM_MAX, 4'd1);
		send_sample(16'h0100);
		send_sample(16'hFF00);
		send_sample(16'h7FFF);
		settle();

		// random part: four idle profiles, a fresh setting every block
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
				default: begin src_idle_pct = 36; sink_stall_pct = 36; end
			endcase
			for (int blk = 0; blk < BLOCKS; blk++) begin
				random_config();
				// long receiver hold-off while the sender keeps pushing: the
				// segment queue fills and s_tready has to drop
				if (ph == 2 && blk == 0)
					hold_cycles = HOLD_CYCLES;
				repeat (BLOCK_BEATS) send_sample(pick_sample());
				settle();
			end
		end

		// top up if big steps left the output side too quiet
		extra = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		if (beats_checked < 48)
			set_config(20'd32768, '0, 4'd8);
		while (beats_checked < 48 && extra < 120) begin
			send_sample(pick_sample());
			extra++;
		end
		settle();

		$display("resampler run: %0d input beats over %0d register settings,", beats_sent,
			settings_used);
		$display("  %0d output beats compared, %0d mismatches", beats_checked, fail_count);
		if (fail_count == 0 && open_beats == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
